// File: hw/rtl/pool2d_pkg.sv
package pool2d_pkg;

	// Register field widths
	localparam int POOL_W  = 4;
	localparam int FRAME_W = 11;

	// Result field widths
	localparam int IDX_W = 10;
	localparam int OFF_W = 3;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Entries in the queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		REG_POOL_ROWS  = 3'd0,
		REG_POOL_COLS  = 3'd1,
		REG_FRAME_COLS = 3'd2,
		REG_FRAME_ROWS = 3'd3,
		REG_USE_MAX    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [POOL_W-1:0]  pool_rows;
		logic [POOL_W-1:0]  pool_cols;
		logic [FRAME_W-1:0] frame_cols;
		logic [FRAME_W-1:0] frame_rows;
		logic               use_max;
	} cfg_t;

	// Per-sample control that the front hands to the back
	typedef struct packed {
		logic             first;
		logic             last;
		logic             frame_done;
		logic [OFF_W-1:0] row_off;
		logic [OFF_W-1:0] col_off;
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
	} win_ctrl_t;

endpackage

// File: hw/rtl/pool2d_in_if.sv
interface pool2d_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          frame_start;

	modport source (output valid, sample, frame_start, input ready);
	modport sink (input valid, sample, frame_start, output ready);
endinterface

// File: hw/rtl/pool2d_out_if.sv
interface pool2d_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] pooled;
	logic [9:0]                    out_row;
	logic [9:0]                    out_col;
	logic [2:0]                    best_row_offset;
	logic [2:0]                    best_col_offset;
	logic                          frame_done;

	modport source (output valid, pooled, out_row, out_col, best_row_offset,
		best_col_offset, frame_done, input ready);
	modport sink (input valid, pooled, out_row, out_col, best_row_offset,
		best_col_offset, frame_done, output ready);
endinterface

// File: hw/rtl/pool2d_max_min_argmax.sv
// Streaming 2-D max/min pooling with argmax. Samples arrive in raster order,
// one per request; each non-overlapping pool_rows x pool_cols window yields one
// result (pooled value, window row/col, winner offset, frame_done on the last
// window of a frame). Ties keep the earlier sample; partial windows at the
// right and bottom edges are dropped. The block sustains one sample per clock
// while results are taken as presented: the line store is read and written
// back once per sample through a single update stage with a bypass for
// back-to-back hits on one column. A window's last accepted sample passes
// the first and second front stages, the queue, the update stage and the
// output register before its result is presented. Registers
// (APB, 4-byte stride): 0 pool_rows, 1 pool_cols, 2 frame_cols, 3 frame_rows,
// 4 use_max; write them only while no sample is in flight. The line store
// powers up undefined and needs no clearing.
module pool2d_max_min_argmax import pool2d_pkg::*; #(
	parameter int MAX_LINE    = 1024,
	parameter int MAX_POOL    = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	pool2d_in_if.sink         samples,
	pool2d_out_if.source      results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
	localparam int QW = $bits(win_ctrl_t) + AW + SAMPLE_BITS;

	// Configuration registers
	cfg_t     cfg_q;
	reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pool_rows  <= POOL_W'(2);
			cfg_q.pool_cols  <= POOL_W'(2);
			cfg_q.frame_cols <= FRAME_W'(1024);
			cfg_q.frame_rows <= FRAME_W'(1024);
			cfg_q.use_max    <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_POOL_ROWS:  cfg_q.pool_rows  <= pwdata[POOL_W-1:0];
				REG_POOL_COLS:  cfg_q.pool_cols  <= pwdata[POOL_W-1:0];
				REG_FRAME_COLS: cfg_q.frame_cols <= pwdata[FRAME_W-1:0];
				REG_FRAME_ROWS: cfg_q.frame_rows <= pwdata[FRAME_W-1:0];
				REG_USE_MAX:    cfg_q.use_max    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_POOL_ROWS:  prdata = DATA_W'(cfg_q.pool_rows);
			REG_POOL_COLS:  prdata = DATA_W'(cfg_q.pool_cols);
			REG_FRAME_COLS: prdata = DATA_W'(cfg_q.frame_cols);
			REG_FRAME_ROWS: prdata = DATA_W'(cfg_q.frame_rows);
			REG_USE_MAX:    prdata = DATA_W'(cfg_q.use_max);
			default:        prdata = '0;
		endcase
	end

	// Front: count positions and classify samples
	logic                          push, pop, q_nonempty;
	win_ctrl_t                     push_ctrl, pop_ctrl;
	logic [AW-1:0]                 push_addr, pop_addr;
	logic signed [SAMPLE_BITS-1:0] push_sample, pop_sample;
	logic [LVL_W-1:0]              q_level;
	logic [QW-1:0]                 pop_data;

	pool2d_front #(
		.MAX_LINE    (MAX_LINE),
		.MAX_POOL    (MAX_POOL),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (samples.valid),
		.in_ready       (samples.ready),
		.in_sample      (samples.sample),
		.in_frame_start (samples.frame_start),
		.q_level        (q_level),
		.push           (push),
		.push_ctrl      (push_ctrl),
		.push_addr      (push_addr),
		.push_sample    (push_sample)
	);

	pool2d_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ctrl, push_addr, push_sample}),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (q_nonempty),
		.level     (q_level)
	);

	assign {pop_ctrl, pop_addr, pop_sample} = pop_data;

	// Back: update the line store and emit results
	logic                          res_valid;
	logic signed [SAMPLE_BITS-1:0] res_pooled;
	win_ctrl_t                     res_ctrl;

	pool2d_back #(
		.MAX_LINE    (MAX_LINE),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.use_max    (cfg_q.use_max),
		.q_valid    (q_nonempty),
		.q_pop      (pop),
		.q_ctrl     (pop_ctrl),
		.q_addr     (pop_addr),
		.q_sample   (pop_sample),
		.res_valid  (res_valid),
		.res_ready  (results.ready),
		.res_pooled (res_pooled),
		.res_ctrl   (res_ctrl)
	);

	assign results.valid           = res_valid;
	assign results.pooled          = res_pooled;
	assign results.out_row         = res_ctrl.out_row;
	assign results.out_col         = res_ctrl.out_col;
	assign results.best_row_offset = res_ctrl.row_off;
	assign results.best_col_offset = res_ctrl.col_off;
	assign results.frame_done      = res_ctrl.frame_done;

endmodule

// File: hw/rtl/pool2d_front.sv
module pool2d_front import pool2d_pkg::*; #(
	parameter int MAX_LINE    = 1024,
	parameter int MAX_POOL    = 8,
	parameter int SAMPLE_BITS = 16,
	parameter int AW          = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_frame_start,
	input  logic [LVL_W-1:0]              q_level,
	output logic                          push,
	output win_ctrl_t                     push_ctrl,
	output logic [AW-1:0]                 push_addr,
	output logic signed [SAMPLE_BITS-1:0] push_sample
);

	localparam int POS_W  = $clog2(MAX_LINE + 1);
	localparam int PB_W   = $clog2(MAX_POOL + 1);
	localparam int IW     = (PB_W > OFF_W) ? PB_W : OFF_W;
	localparam int TI_W   = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
	localparam int RS     = POS_W + 5;
	localparam int RW     = RS + 1;
	localparam int PROD_W = POS_W + RW;

	// Reciprocal table: x / d == (x * ceil(2^RS / d)) >> RS for x < 2^POS_W
	logic [RW-1:0] recip_tab [0:(1<<TI_W)-1];

	for (genvar d = 0; d < (1 << TI_W); d++) begin : g_recip
		localparam int DIV = (d + 1 <= MAX_POOL) ? d + 1 : MAX_POOL;
		localparam logic [RW-1:0] RECIP = RW'(((longint'(1) << RS) + DIV - 1) / DIV);
		assign recip_tab[d] = RECIP;
	end

	// Clamped sizes
	logic [IW-1:0]    pr_c, pc_c;
	logic [POS_W-1:0] fr_c, fc_c;
	logic [IW-1:0]    pr_m1, pc_m1;

	always_comb begin
		pr_c = (cfg.pool_rows == '0) ? IW'(1) :
			((int'(cfg.pool_rows) > MAX_POOL) ? IW'(MAX_POOL) : IW'(cfg.pool_rows));
		pc_c = (cfg.pool_cols == '0) ? IW'(1) :
			((int'(cfg.pool_cols) > MAX_POOL) ? IW'(MAX_POOL) : IW'(cfg.pool_cols));
		fr_c = (cfg.frame_rows == '0) ? POS_W'(1) :
			((int'(cfg.frame_rows) > MAX_LINE) ? POS_W'(MAX_LINE) : POS_W'(cfg.frame_rows));
		fc_c = (cfg.frame_cols == '0) ? POS_W'(1) :
			((int'(cfg.frame_cols) > MAX_LINE) ? POS_W'(MAX_LINE) : POS_W'(cfg.frame_cols));
		pr_m1 = pr_c - IW'(1);
		pc_m1 = pc_c - IW'(1);
	end

	// Window counts per frame, refreshed from the registers every cycle
	logic [PROD_W-1:0] oc_prod, or_prod;
	logic [POS_W-1:0]  out_cols_q, out_rows_q;

	assign oc_prod = PROD_W'(fc_c) * PROD_W'(recip_tab[pc_m1[TI_W-1:0]]);
	assign or_prod = PROD_W'(fr_c) * PROD_W'(recip_tab[pr_m1[TI_W-1:0]]);

	always_ff @(posedge clk) begin
		out_cols_q <= oc_prod[RS +: POS_W];
		out_rows_q <= or_prod[RS +: POS_W];
	end

	// Position counters
	logic [POS_W-1:0] col_pos_q, row_pos_q;
	logic [IW-1:0]    cin_q, rin_q;
	logic [POS_W-1:0] col_e, row_e;
	logic [IW-1:0]    cin_e, rin_e;
	logic [POS_W:0]   col_inc, row_inc;
	logic [IW:0]      cin_inc, rin_inc;
	logic [POS_W-1:0] col_nx, row_nx;
	logic [IW-1:0]    cin_nx, rin_nx;
	logic             accept;
	logic             v_s1, v_s2;

	// Credit: keep room in the queue for every sample still in the front
	logic [LVL_W:0] used;

	assign used     = (LVL_W+1)'(q_level) + (LVL_W+1)'(v_s1) + (LVL_W+1)'(v_s2);
	assign in_ready = (used < (LVL_W+1)'(QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;

	always_comb begin
		col_e   = in_frame_start ? '0 : col_pos_q;
		row_e   = in_frame_start ? '0 : row_pos_q;
		cin_e   = in_frame_start ? '0 : cin_q;
		rin_e   = in_frame_start ? '0 : rin_q;
		col_inc = (POS_W+1)'(col_e) + (POS_W+1)'(1);
		row_inc = (POS_W+1)'(row_e) + (POS_W+1)'(1);
		cin_inc = (IW+1)'(cin_e) + (IW+1)'(1);
		rin_inc = (IW+1)'(rin_e) + (IW+1)'(1);
		col_nx  = col_inc[POS_W-1:0];
		row_nx  = row_e;
		cin_nx  = (cin_inc >= (IW+1)'(pc_c)) ? '0 : cin_inc[IW-1:0];
		rin_nx  = rin_e;
		// Wrap at end of row, then at end of frame
		if (col_inc >= (POS_W+1)'(fc_c)) begin
			col_nx = '0;
			cin_nx = '0;
			row_nx = row_inc[POS_W-1:0];
			rin_nx = (rin_inc >= (IW+1)'(pr_c)) ? '0 : rin_inc[IW-1:0];
			if (row_inc >= (POS_W+1)'(fr_c)) begin
				row_nx = '0;
				rin_nx = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
			cin_q     <= '0;
			rin_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (accept) begin
				col_pos_q <= col_nx;
				row_pos_q <= row_nx;
				cin_q     <= cin_nx;
				rin_q     <= rin_nx;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: capture sample with its position
	logic signed [SAMPLE_BITS-1:0] sample_s1, sample_s2;
	logic [POS_W-1:0]              col_s1, row_s1;
	logic [IW-1:0]                 cin_s1, rin_s1, cin_s2, rin_s2;
	logic                          last_w1, first_s2, last_s2;
	logic [PROD_W-1:0]             wc_prod, wr_prod;
	logic [POS_W-1:0]              wc_s2, wr_s2;

	assign last_w1 = ((IW+1)'(cin_s1) + (IW+1)'(1) == (IW+1)'(pc_c)) &&
		((IW+1)'(rin_s1) + (IW+1)'(1) == (IW+1)'(pr_c));
	assign wc_prod = PROD_W'(col_s1) * PROD_W'(recip_tab[pc_m1[TI_W-1:0]]);
	assign wr_prod = PROD_W'(row_s1) * PROD_W'(recip_tab[pr_m1[TI_W-1:0]]);

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_sample;
			col_s1    <= col_e;
			row_s1    <= row_e;
			cin_s1    <= cin_e;
			rin_s1    <= rin_e;
		end
		// Stage 2: window index by reciprocal multiply
		sample_s2 <= sample_s1;
		cin_s2    <= cin_s1;
		rin_s2    <= rin_s1;
		first_s2  <= (cin_s1 == '0) && (rin_s1 == '0);
		last_s2   <= last_w1;
		wc_s2     <= wc_prod[RS +: POS_W];
		wr_s2     <= wr_prod[RS +: POS_W];
	end

	// Classify: drop samples outside any whole window
	logic in_range;

	assign in_range = (wc_s2 < out_cols_q) && (wr_s2 < out_rows_q);
	assign push     = v_s2 && in_range;

	always_comb begin
		push_ctrl.first      = first_s2;
		push_ctrl.last       = last_s2;
		push_ctrl.frame_done = ((POS_W+1)'(wr_s2) + (POS_W+1)'(1) == (POS_W+1)'(out_rows_q)) &&
			((POS_W+1)'(wc_s2) + (POS_W+1)'(1) == (POS_W+1)'(out_cols_q));
		push_ctrl.row_off    = rin_s2[OFF_W-1:0];
		push_ctrl.col_off    = cin_s2[OFF_W-1:0];
		push_ctrl.out_row    = IDX_W'(wr_s2);
		push_ctrl.out_col    = IDX_W'(wc_s2);
		push_addr            = AW'(wc_s2);
		push_sample          = sample_s2;
	end

endmodule

// File: hw/rtl/pool2d_queue.sv
module pool2d_queue import pool2d_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             nonempty,
	output logic [LVL_W-1:0] level
);

	logic [WIDTH-1:0]  slot_q [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [LVL_W-1:0]  count_q;

	assign pop_data = slot_q[rptr_q];
	assign nonempty = (count_q != '0);
	assign level    = count_q;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + LVL_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - LVL_W'(1);
			end
		end
	end

	// Store request
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < LVL_W'(QUEUE_DEPTH)) || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");

endmodule

// File: hw/rtl/pool2d_back.sv
module pool2d_back import pool2d_pkg::*; #(
	parameter int MAX_LINE    = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int AW          = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          use_max,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  win_ctrl_t                     q_ctrl,
	input  logic [AW-1:0]                 q_addr,
	input  logic signed [SAMPLE_BITS-1:0] q_sample,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic signed [SAMPLE_BITS-1:0] res_pooled,
	output win_ctrl_t                     res_ctrl
);

	localparam int EW = SAMPLE_BITS + 2 * OFF_W;

	// Line store: running best and its offsets per window column
	logic [EW-1:0] line_mem [0:MAX_LINE-1];

	logic                          b1_valid_q;
	win_ctrl_t                     b1_ctrl_q;
	logic [AW-1:0]                 b1_addr_q;
	logic signed [SAMPLE_BITS-1:0] b1_sample_q;
	logic [EW-1:0]                 rd_q;

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [EW-1:0] fwd_entry_q;

	logic                          res_valid_q;
	logic signed [SAMPLE_BITS-1:0] res_pooled_q;
	win_ctrl_t                     res_ctrl_q;

	logic [EW-1:0]                 cur_entry, new_entry;
	logic signed [SAMPLE_BITS-1:0] cur_best;
	logic                          take, out_free, b1_fire;
	win_ctrl_t                     res_ctrl_d;

	// Take the latest write when it hits the same column
	always_comb begin
		cur_entry = (fwd_valid_q && (fwd_addr_q == b1_addr_q)) ? fwd_entry_q : rd_q;
		cur_best  = cur_entry[EW-1 -: SAMPLE_BITS];
		if (b1_ctrl_q.first) begin
			take = 1'b1;
		end else if (use_max) begin
			take = b1_sample_q > cur_best;
		end else begin
			take = b1_sample_q < cur_best;
		end
		new_entry = take ? {b1_sample_q, b1_ctrl_q.row_off, b1_ctrl_q.col_off} : cur_entry;
		// Result carries the winner's offsets in place of the sample's own
		res_ctrl_d         = b1_ctrl_q;
		res_ctrl_d.row_off = new_entry[2*OFF_W-1 -: OFF_W];
		res_ctrl_d.col_off = new_entry[OFF_W-1:0];
	end

	assign out_free = !res_valid_q || res_ready;
	assign b1_fire  = b1_valid_q && (!b1_ctrl_q.last || out_free);
	assign q_pop    = q_valid && (!b1_valid_q || b1_fire);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q  <= 1'b0;
			fwd_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				b1_valid_q <= 1'b1;
			end else if (b1_fire) begin
				b1_valid_q <= 1'b0;
			end
			if (b1_fire) begin
				fwd_valid_q <= 1'b1;
			end
			if (b1_fire && b1_ctrl_q.last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Read, update and write back the line store
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_q        <= line_mem[q_addr];
			b1_ctrl_q   <= q_ctrl;
			b1_addr_q   <= q_addr;
			b1_sample_q <= q_sample;
		end
		if (b1_fire) begin
			line_mem[b1_addr_q] <= new_entry;
			fwd_addr_q          <= b1_addr_q;
			fwd_entry_q         <= new_entry;
		end
		if (b1_fire && b1_ctrl_q.last) begin
			res_pooled_q <= new_entry[EW-1 -: SAMPLE_BITS];
			res_ctrl_q   <= res_ctrl_d;
		end
	end

	assign res_valid  = res_valid_q;
	assign res_pooled = res_pooled_q;
	assign res_ctrl   = res_ctrl_q;

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> b1_valid_q)
		else $error("popped request not held in update stage");

	a_fwd_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		b1_fire |=> fwd_valid_q && (fwd_addr_q == $past(b1_addr_q)))
		else $error("bypass does not hold latest line store write");

endmodule
